// ===== src/pcrm_pkg.sv =====
// Shared constants, register indexes, the exponent table and the root function for the power curve range map.
// Used by power_curve_range_map_top; depends on nothing else.
`default_nettype none
package pcrm_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CURVE_W = 5;
  localparam int FRAC_W = 16;
  localparam int QUO_W = FRAC_W + 1;
  localparam int LOG_STEPS = 31;
  localparam int EXP_STEPS = 31;
  localparam int EXPO_W = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_IN_MIN = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IN_MAX = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_OUT_BEGIN = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_OUT_END = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_CURVE = 3'd4;

  localparam logic signed [CURVE_W-1:0] CURVE_MAX = 5'sd10;
  localparam logic signed [CURVE_W-1:0] CURVE_MIN = -5'sd10;

  // Exponent 10^(-c/10) in Q4.12 for curve settings -10 to 10.
  localparam logic [EXPO_W-1:0] EXP_TABLE [21] = '{
    16'd40960, 16'd32536, 16'd25844, 16'd20529, 16'd16306, 16'd12953, 16'd10289,
    16'd8173, 16'd6492, 16'd5157, 16'd4096, 16'd3254, 16'd2584, 16'd2053,
    16'd1631, 16'd1295, 16'd1029, 16'd817, 16'd649, 16'd516, 16'd410
  };

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] rem;
    r = '0;
    b = 64'd1 << 62;
    rem = v;
    for (int i = 0; i < 32; i++) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Q1.31 value of 2^(-2^-j), built by repeated truncated square roots of one half.
  function automatic logic [31:0] exp_root(input int j);
    logic [63:0] c;
    c = 64'd1 << 30;
    for (int i = 0; i < j; i++) begin
      c = isqrt64(c << 31);
    end
    return c[31:0];
  endfunction

endpackage
`default_nettype wire

// ===== src/power_curve_range_map_top.sv =====
// Power curve range map: clamp, normalize, raise to a power, rescale; one sample per cycle unless stalled.
// Depends on pcrm_pkg for register indexes, the exponent table and the root constants.
//
// Usage: samples enter on the input channel (in_valid_i, in_stall_o, sample_in_i) and
// results leave on the output channel (out_valid_o, out_stall_i, mapped_out_o,
// range_error_o), one result for every sample, in order. An item moves when valid
// is high and stall is low. The configuration channel (cfg_valid_i, cfg_ready_o,
// cfg_index_i, cfg_data_i) writes in_min, in_max, out_begin, out_end and
// curve_setting at indexes 0 to 4; it is always ready, and writes belong in idle time.
// One sample is taken every cycle unless the output channel stalls.
// The depth comes from the 17-step restoring divider, the 31 squaring stages of the
// logarithm and the 31 multiply stages of the power of two, one step per stage.
// Reset clears all valid bits and loads the register defaults. When the receiver
// stalls with a result waiting, the whole pipeline holds and in_stall_o rises in
// the same cycle; nothing is lost or repeated.
`default_nettype none
module power_curve_range_map_top #(
  parameter int SAMPLE_WIDTH = pcrm_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic [SAMPLE_WIDTH-1:0]              sample_in_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic [SAMPLE_WIDTH-1:0]                   mapped_out_o,
  output logic                                      range_error_o,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [pcrm_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  wire logic [SAMPLE_WIDTH-1:0]              cfg_data_i
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int QW = pcrm_pkg::QUO_W;
  localparam int LN = pcrm_pkg::LOG_STEPS;
  localparam int EN = pcrm_pkg::EXP_STEPS;
  localparam int SC_W = 32 + SW;

  logic [SW-1:0] in_min_q, in_max_q, out_begin_q, out_end_q;
  logic [pcrm_pkg::CURVE_W-1:0] curve_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_min_q <= '0;
      in_max_q <= '1;
      out_begin_q <= '0;
      out_end_q <= '1;
      curve_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        pcrm_pkg::CFG_IN_MIN: in_min_q <= cfg_data_i;
        pcrm_pkg::CFG_IN_MAX: in_max_q <= cfg_data_i;
        pcrm_pkg::CFG_OUT_BEGIN: out_begin_q <= cfg_data_i;
        pcrm_pkg::CFG_OUT_END: out_end_q <= cfg_data_i;
        pcrm_pkg::CFG_CURVE: curve_q <= cfg_data_i[pcrm_pkg::CURVE_W-1:0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic out_valid_q;
  assign adv = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  logic [SW-1:0] den;
  logic [SW-1:0] x_c, diff;
  logic q_top;
  assign den = in_max_q - in_min_q;
  assign x_c = (sample_in_i < in_min_q) ? in_min_q :
               (sample_in_i > in_max_q) ? in_max_q : sample_in_i;
  assign diff = x_c - in_min_q;
  assign q_top = diff >= den;

  logic [SW-1:0] div_rem_q [QW];
  logic [QW-1:0] div_quo_q [QW];
  logic          div_v_q   [QW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_v_q[0] <= 1'b0;
    end else if (adv) begin
      div_v_q[0] <= in_valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      div_rem_q[0] <= q_top ? diff - den : diff;
      div_quo_q[0] <= QW'(q_top);
    end
  end

  for (genvar i = 1; i < QW; i++) begin : g_div
    logic [SW:0] r2;
    logic ge;
    assign r2 = {div_rem_q[i-1], 1'b0};
    assign ge = r2 >= {1'b0, den};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_v_q[i] <= 1'b0;
      end else if (adv) begin
        div_v_q[i] <= div_v_q[i-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        div_rem_q[i] <= ge ? SW'(r2 - {1'b0, den}) : SW'(r2);
        div_quo_q[i] <= {div_quo_q[i-1][QW-2:0], ge};
      end
    end
  end

  logic [QW-1:0] n_val;
  logic [4:0] n_k;
  assign n_val = div_quo_q[QW-1];
  always_comb begin
    n_k = '0;
    for (int b = 0; b < QW; b++) begin
      if (n_val[b]) begin
        n_k = 5'(b);
      end
    end
  end

  logic [31:0] lg_m_q  [LN+1];
  logic [30:0] lg_f_q  [LN+1];
  logic [4:0]  lg_k_q  [LN+1];
  logic        lg_nz_q [LN+1];
  logic        lg_v_q  [LN+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lg_v_q[0] <= 1'b0;
    end else if (adv) begin
      lg_v_q[0] <= div_v_q[QW-1];
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      lg_m_q[0] <= 32'(n_val) << (5'd31 - n_k);
      lg_f_q[0] <= '0;
      lg_k_q[0] <= n_k;
      lg_nz_q[0] <= n_val != '0;
    end
  end

  for (genvar i = 1; i <= LN; i++) begin : g_log
    logic [63:0] sq;
    logic [32:0] t;
    assign sq = 64'(lg_m_q[i-1]) * 64'(lg_m_q[i-1]);
    assign t = sq[63:31];
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        lg_v_q[i] <= 1'b0;
      end else if (adv) begin
        lg_v_q[i] <= lg_v_q[i-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        lg_m_q[i] <= t[32] ? t[32:1] : t[31:0];
        lg_f_q[i] <= {lg_f_q[i-1][29:0], t[32]};
        lg_k_q[i] <= lg_k_q[i-1];
        lg_nz_q[i] <= lg_nz_q[i-1];
      end
    end
  end

  logic signed [pcrm_pkg::CURVE_W-1:0] curve_s, curve_c;
  logic [pcrm_pkg::CURVE_W-1:0] tab_idx;
  logic [pcrm_pkg::EXPO_W-1:0] expo;
  assign curve_s = curve_q;
  assign curve_c = (curve_s > pcrm_pkg::CURVE_MAX) ? pcrm_pkg::CURVE_MAX :
                   (curve_s < pcrm_pkg::CURVE_MIN) ? pcrm_pkg::CURVE_MIN : curve_s;
  assign tab_idx = curve_c - pcrm_pkg::CURVE_MIN;
  assign expo = pcrm_pkg::EXP_TABLE[tab_idx];

  logic [35:0] mg_q;
  logic mg_nz_q, mg_v_q;
  logic [51:0] y_q;
  logic y_nz_q, y_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mg_v_q <= 1'b0;
      y_v_q <= 1'b0;
    end else if (adv) begin
      mg_v_q <= lg_v_q[LN];
      y_v_q <= mg_v_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      mg_q <= (36'(5'd16 - lg_k_q[LN]) << 31) - 36'(lg_f_q[LN]);
      mg_nz_q <= lg_nz_q[LN];
      y_q <= 52'(mg_q) * 52'(expo);
      y_nz_q <= mg_nz_q;
    end
  end

  logic [31:0] ex_p_q  [EN+1];
  logic [30:0] ex_f_q  [EN+1];
  logic [8:0]  ex_ip_q [EN+1];
  logic        ex_nz_q [EN+1];
  logic        ex_v_q  [EN+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_v_q[0] <= 1'b0;
    end else if (adv) begin
      ex_v_q[0] <= y_v_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ex_p_q[0] <= 32'd1 << 31;
      ex_f_q[0] <= y_q[42:12];
      ex_ip_q[0] <= y_q[51:43];
      ex_nz_q[0] <= y_nz_q;
    end
  end

  for (genvar j = 1; j <= EN; j++) begin : g_exp
    localparam logic [31:0] ROOT = pcrm_pkg::exp_root(j);
    logic [63:0] prod;
    assign prod = 64'(ex_p_q[j-1]) * 64'(ROOT);
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ex_v_q[j] <= 1'b0;
      end else if (adv) begin
        ex_v_q[j] <= ex_v_q[j-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        ex_p_q[j] <= ex_f_q[j-1][31-j] ? prod[62:31] : ex_p_q[j-1];
        ex_f_q[j] <= ex_f_q[j-1];
        ex_ip_q[j] <= ex_ip_q[j-1];
        ex_nz_q[j] <= ex_nz_q[j-1];
      end
    end
  end

  logic up;
  logic [SW-1:0] range_w;
  assign up = out_end_q > out_begin_q;
  assign range_w = up ? out_end_q - out_begin_q : out_begin_q - out_end_q;

  logic [31:0] sh_p_q;
  logic sh_v_q;
  logic [SC_W-1:0] sc_q;
  logic sc_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sh_v_q <= 1'b0;
      sc_v_q <= 1'b0;
    end else if (adv) begin
      sh_v_q <= ex_v_q[EN];
      sc_v_q <= sh_v_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sh_p_q <= (ex_nz_q[EN] && ex_ip_q[EN] < 9'd32) ?
                ex_p_q[EN] >> ex_ip_q[EN][4:0] : '0;
      sc_q <= SC_W'(sh_p_q) * SC_W'(range_w);
    end
  end

  logic [SC_W:0] rnd;
  logic [SC_W-31:0] res_w;
  logic [SW-1:0] res_c;
  logic range_err;
  assign rnd = {1'b0, sc_q} + ((SC_W + 1)'(1) << 30);
  assign res_w = rnd[SC_W:31];
  assign res_c = (res_w > (SC_W - 30)'(range_w)) ? range_w : res_w[SW-1:0];
  assign range_err = in_min_q >= in_max_q;

  logic [SW-1:0] mapped_q;
  logic err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= sc_v_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      mapped_q <= range_err ? '0 : (up ? out_begin_q + res_c : out_begin_q - res_c);
      err_q <= range_err;
    end
  end

  assign out_valid_o = out_valid_q;
  assign mapped_out_o = mapped_q;
  assign range_error_o = err_q;

`ifndef NO_ASSERTIONS
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && range_error_o |-> mapped_out_o == '0)
    else $error("range error result is not zero");
  a_stall_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not follow output backpressure");
  a_hold_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(sc_v_q) && $stable(sc_q))
    else $error("pipeline moved during a stall");
`endif

endmodule
`default_nettype wire

// ===== sim/tb_power_curve_range_map_top.sv =====
// Self-checking testbench for power_curve_range_map_top: random and directed samples,
// register settings, input gaps and output stalls, checked against a built-in curve predictor.
// Depends on pcrm_pkg and the block's RTL.
`timescale 1ns / 100ps
`default_nettype none

class curve_map_scoreboard;
  logic [15:0] want_map_q[$];
  logic        want_err_q[$];
  int          fails;

  function void note_request(logic [15:0] mapped, logic err);
    want_map_q.push_back(mapped);
    want_err_q.push_back(err);
  endfunction

  function void check_result(logic [15:0] mapped, logic err);
    logic [15:0] wm;
    logic        we;
    if (want_map_q.size() == 0) begin
      $error("unexpected result mapped_out %0d", mapped);
      fails++;
      return;
    end
    wm = want_map_q.pop_front();
    we = want_err_q.pop_front();
    if (wm !== mapped) begin
      $error("mapped_out expected %0d actual %0d", wm, mapped);
      fails++;
    end
    if (we !== err) begin
      $error("range_error expected %0d actual %0d", we, err);
      fails++;
    end
  endfunction

  function int pending();
    return want_map_q.size();
  endfunction
endclass

module tb_power_curve_range_map_top;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [15:0] sample_in_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [15:0] mapped_out_o;
  logic range_error_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [pcrm_pkg::CFG_INDEX_W-1:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  logic [15:0] lo_reg, hi_reg, ob_reg, oe_reg;
  logic [4:0] curve_reg;
  logic [31:0] root_tab [1:31];
  bit sending;
  curve_map_scoreboard sb;

  power_curve_range_map_top u_top (.*);

  always #5 clk_i = ~clk_i;

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] log2_mag(logic [63:0] n);
    int k;
    logic [63:0] m, frac;
    k = 0;
    frac = '0;
    while (k < 16 && (n >> (k + 1)) != 0) k++;
    m = n << (31 - k);
    for (int i = 0; i < 31; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= (64'd1 << 32)) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    return (64'd16 << 31) - ((64'(k) << 31) | frac);
  endfunction

  function automatic logic [63:0] pow2_neg(logic [63:0] y);
    logic [63:0] ip, f, p;
    ip = y >> 43;
    f = (y & ((64'd1 << 43) - 1)) >> 12;
    p = 64'd1 << 31;
    if (ip >= 40) return 0;
    for (int j = 1; j <= 31; j++)
      if (f[31 - j]) p = (p * root_tab[j]) >> 31;
    return p >> ip;
  endfunction

  function automatic void predict_curve(logic [15:0] s, output logic [15:0] m,
                                        output logic e);
    int c;
    logic [63:0] x, n, p, rng, res;
    bit up;
    m = '0;
    e = 1'b1;
    if (lo_reg >= hi_reg) return;
    e = 1'b0;
    c = $signed(curve_reg);
    if (c > 10) c = 10;
    if (c < -10) c = -10;
    x = s;
    if (x < lo_reg) x = lo_reg;
    if (x > hi_reg) x = hi_reg;
    n = ((x - lo_reg) << 16) / (hi_reg - lo_reg);
    p = (n == 0) ? 0 : pow2_neg(log2_mag(n) * pcrm_pkg::EXP_TABLE[c + 10]);
    up = oe_reg > ob_reg;
    rng = up ? oe_reg - ob_reg : ob_reg - oe_reg;
    res = (p * rng + (64'd1 << 30)) >> 31;
    if (res > rng) res = rng;
    m = up ? 16'(ob_reg + res) : 16'(ob_reg - res);
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic write_reg(logic [pcrm_pkg::CFG_INDEX_W-1:0] idx, logic [15:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      pcrm_pkg::CFG_IN_MIN: lo_reg = d;
      pcrm_pkg::CFG_IN_MAX: hi_reg = d;
      pcrm_pkg::CFG_OUT_BEGIN: ob_reg = d;
      pcrm_pkg::CFG_OUT_END: oe_reg = d;
      pcrm_pkg::CFG_CURVE: curve_reg = d[4:0];
      default: ;
    endcase
  endtask

  task automatic send_sample(logic [15:0] s);
    logic [15:0] m;
    logic e;
    in_valid_i <= 1'b1;
    sample_in_i <= s;
    do @(posedge clk_i); while (in_stall_o);
    predict_curve(s, m, e);
    sb.note_request(m, e);
  endtask

  task automatic send_burst(int cnt, bit use_gaps);
    int g;
    for (int i = 0; i < cnt; i++) begin
      send_sample(16'($urandom()));
      g = use_gaps ? gap_len() : 0;
      if (g > 0) begin
        in_valid_i <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic set_all(logic [15:0] a, logic [15:0] b, logic [15:0] c, logic [15:0] d,
                         logic [4:0] k);
    write_reg(pcrm_pkg::CFG_IN_MIN, a);
    write_reg(pcrm_pkg::CFG_IN_MAX, b);
    write_reg(pcrm_pkg::CFG_OUT_BEGIN, c);
    write_reg(pcrm_pkg::CFG_OUT_END, d);
    write_reg(pcrm_pkg::CFG_CURVE, {11'd0, k});
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(mapped_out_o, range_error_o);
  end

  initial begin
    int g;
    forever begin
      @(posedge clk_i);
      g = $urandom_range(0, 99);
      if (!sending || g < 50) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b1;
        repeat (gap_len()) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    logic [63:0] c;
    logic [15:0] a, b;
    sb = new();
    c = 64'd1 << 30;
    for (int j = 1; j <= 31; j++) begin
      c = int_sqrt(c << 31);
      root_tab[j] = c[31:0];
    end
    lo_reg = 0; hi_reg = 16'hFFFF; ob_reg = 0; oe_reg = 16'hFFFF; curve_reg = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    sending = 1;
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h8000);
    send_sample(16'h0001);
    in_valid_i <= 1'b0;
    drain();
    set_all(16'd1000, 16'd3000, 16'd500, 16'd60000, 5'd10);
    for (int i = 0; i < 16; i++) send_sample(16'(1) << i);
    send_sample(16'd999);
    send_sample(16'd1001);
    send_sample(16'd3000);
    in_valid_i <= 1'b0;
    drain();
    write_reg(pcrm_pkg::CFG_CURVE, 16'h0016);
    write_reg(pcrm_pkg::CFG_OUT_BEGIN, 16'hFFFF);
    write_reg(pcrm_pkg::CFG_OUT_END, 16'h0000);
    send_sample(16'd2000);
    send_sample(16'd1001);
    send_sample(16'd5000);
    in_valid_i <= 1'b0;
    drain();
    write_reg(pcrm_pkg::CFG_CURVE, 16'h000F);
    send_sample(16'd2999);
    in_valid_i <= 1'b0;
    drain();
    set_all(16'd3000, 16'd3000, 16'd0, 16'd9, 5'd0);
    send_sample(16'd3000);
    in_valid_i <= 1'b0;
    drain();
    write_reg(pcrm_pkg::CFG_IN_MIN, 16'd4000);
    send_sample(16'd100);
    in_valid_i <= 1'b0;
    drain();
    for (int ph = 0; ph < 12; ph++) begin
      a = 16'($urandom());
      b = 16'($urandom());
      if (ph == 0) begin
        a = 0; b = 16'hFFFF;
      end else if (ph < 10 && a > b) begin
        {a, b} = {b, a};
      end else if (ph % 3 == 0) begin
        a = 16'($urandom_range(0, 300)); b = a + 16'($urandom_range(1, 8));
      end
      set_all(a, b, 16'($urandom()), 16'($urandom()),
              (ph == 1) ? 5'h16 : (ph == 2) ? 5'd10 : 5'($urandom_range(0, 31)));
      send_burst(60, ph % 4 != 3);
      drain();
    end
    sending = 0;
    drain();
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ===== files.f =====
src/pcrm_pkg.sv
src/power_curve_range_map_top.sv
sim/tb_power_curve_range_map_top.sv
